FILE: rtl/core/pdet_pkg.sv
// Shared types and constants for the PPS-disciplined event timestamper.
// Holds the opcode enum, the queued item and the packed result layout.
// No dependencies.
`default_nettype none

package pdet_pkg;

	// Width of the capture field and of every 32-bit result field
	localparam int CAP_W   = 32;
	localparam int SLOT_W  = 8;
	localparam int OP_W    = 2;
	localparam int OUT_W   = 208;
	localparam int PAD_W   = OUT_W - (6 * CAP_W + SLOT_W + 3);

	// Event kinds carried on the input tuser
	typedef enum logic [OP_W-1:0] {
		OP_DETECT = 2'd0,
		OP_PPS    = 2'd1,
		OP_EXPIRY = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// One classified event between front and back
	typedef struct packed {
		op_t              op;
		logic [CAP_W-1:0] cap;
	} item_t;

	// Result word; first member is the most significant, so the packed
	// value puts ray_period in the lowest bits
	typedef struct packed {
		logic [PAD_W-1:0]  pad;
		logic [CAP_W-1:0]  events_total;
		logic              stack_full;
		logic              holdover_pulse;
		logic [CAP_W-1:0]  seconds_seen;
		logic              gps_lock;
		logic [CAP_W-1:0]  pps_period;
		logic [SLOT_W-1:0] event_slot;
		logic [CAP_W-1:0]  event_time;
		logic [CAP_W-1:0]  ray_after_pps;
		logic [CAP_W-1:0]  ray_period;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/core/pdet_front.sv
// Front end: accepts input events, classifies the opcode and masks the
// capture to the counter width. Depends on pdet_pkg.
`default_nettype none

module pdet_front #(
	parameter int COUNTER_BITS = 32
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire [pdet_pkg::CAP_W-1:0]  s_axis_tdata,
	input  wire [pdet_pkg::OP_W-1:0]   s_axis_tuser,
	output logic                       push_valid,
	input  wire                        push_ready,
	output pdet_pkg::item_t            push_item
);
	import pdet_pkg::*;

	localparam int DW = (COUNTER_BITS < CAP_W) ? COUNTER_BITS : CAP_W;
	localparam logic [CAP_W-1:0] CAP_MASK = {CAP_W{1'b1}} >> (CAP_W - DW);

	logic  valid_s1;
	item_t item_s1;
	logic  accept;

	// Take a new request whenever the stage is empty or drains this cycle
	assign s_axis_tready = !valid_s1 || push_ready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Classify and mask the capture
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op  <= op_t'(s_axis_tuser);
			item_s1.cap <= s_axis_tdata & CAP_MASK;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

`default_nettype wire

FILE: rtl/core/pdet_fifo.sv
// Two-entry queue between the front end and the execute stage.
// Depends on pdet_pkg for the item type.
`default_nettype none

module pdet_fifo (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push_valid,
	output logic             push_ready,
	input  pdet_pkg::item_t  push_item,
	output logic             pop_valid,
	input  wire              pop_ready,
	output pdet_pkg::item_t  pop_item
);
	import pdet_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop) count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

	// Store the entry
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule

`default_nettype wire

FILE: rtl/core/pdet_back.sv
// Execute stage: holds the timing state, applies each event and registers
// the result for the output stream. Depends on pdet_pkg.
`default_nettype none

module pdet_back #(
	parameter int MAX_EVENTS   = 128,
	parameter int COUNTER_BITS = 32
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       pop_valid,
	output logic                      pop_ready,
	input  pdet_pkg::item_t           pop_item,
	output logic                      m_axis_tvalid,
	input  wire                       m_axis_tready,
	output logic [pdet_pkg::OUT_W-1:0] m_axis_tdata
);
	import pdet_pkg::*;

	localparam int DW  = (COUNTER_BITS < CAP_W) ? COUNTER_BITS : CAP_W;
	localparam int SCW = $clog2(MAX_EVENTS + 1);
	localparam logic [SCW-1:0] MAX_CNT = SCW'(MAX_EVENTS);

	// Timing state
	logic [DW-1:0]    ray_ref_q;
	logic [DW-1:0]    pps_ref_q;
	logic [DW-1:0]    reload_q;
	logic             pps_seen_q;
	logic             lock_q;
	logic [CAP_W-1:0] seconds_q;
	logic [SCW-1:0]   stack_cnt_q;
	logic [CAP_W-1:0] last_evt_q;
	logic [CAP_W-1:0] events_q;

	// Output register
	logic    out_valid_q;
	result_t res_q;

	logic             fire;
	logic [DW-1:0]    cap_d;
	logic [DW-1:0]    diff_ray;
	logic [DW-1:0]    diff_pps;
	logic [CAP_W-1:0] ray32;
	logic             full;
	logic [CAP_W-1:0] evt_sum;

	logic [DW-1:0]    ray_ref_d;
	logic [DW-1:0]    pps_ref_d;
	logic [DW-1:0]    reload_d;
	logic             pps_seen_d;
	logic             lock_d;
	logic [CAP_W-1:0] seconds_d;
	logic [SCW-1:0]   stack_cnt_d;
	logic [CAP_W-1:0] last_evt_d;
	logic [CAP_W-1:0] events_d;
	result_t          res_d;

	assign pop_ready = !out_valid_q || m_axis_tready;
	assign fire      = pop_valid && pop_ready;

	// Modular differences against the stored references
	assign cap_d    = pop_item.cap[DW-1:0];
	assign diff_ray = cap_d - ray_ref_q;
	assign diff_pps = cap_d - pps_ref_q;
	assign ray32    = CAP_W'(diff_ray);
	assign full     = (stack_cnt_q == MAX_CNT);
	assign evt_sum  = (stack_cnt_q != '0) ? (last_evt_q + ray32) : ray32;

	// Apply the event to state and build the result
	always_comb begin
		ray_ref_d   = ray_ref_q;
		pps_ref_d   = pps_ref_q;
		reload_d    = reload_q;
		pps_seen_d  = pps_seen_q;
		lock_d      = lock_q;
		seconds_d   = seconds_q;
		stack_cnt_d = stack_cnt_q;
		last_evt_d  = last_evt_q;
		events_d    = events_q;
		res_d       = '0;
		case (pop_item.op)
			OP_DETECT: begin
				res_d.ray_period    = ray32;
				res_d.ray_after_pps = CAP_W'(diff_pps);
				res_d.event_slot    = SLOT_W'(stack_cnt_q);
				ray_ref_d           = cap_d;
				if (full) begin
					res_d.stack_full = 1'b1;
					res_d.event_time = last_evt_q;
				end else begin
					res_d.event_time = evt_sum;
					last_evt_d       = evt_sum;
					stack_cnt_d      = stack_cnt_q + SCW'(1);
				end
				events_d = events_q + CAP_W'(1);
			end
			OP_PPS: begin
				res_d.pps_period = CAP_W'(diff_pps);
				pps_ref_d        = cap_d;
				reload_d         = diff_pps;
				ray_ref_d        = cap_d;
				seconds_d        = seconds_q + CAP_W'(1);
				lock_d           = 1'b1;
				pps_seen_d       = 1'b1;
			end
			OP_EXPIRY: begin
				// Synthesize a second when no PPS arrived since last expiry
				if (!pps_seen_q) begin
					res_d.holdover_pulse = 1'b1;
					lock_d               = 1'b0;
					seconds_d            = seconds_q + CAP_W'(1);
				end
				pps_seen_d       = 1'b0;
				res_d.pps_period = CAP_W'(reload_q);
			end
			default: begin
			end
		endcase
		res_d.gps_lock     = lock_d;
		res_d.seconds_seen = seconds_d;
		res_d.events_total = events_d;
	end

	// Hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_ref_q   <= '0;
			pps_ref_q   <= '0;
			reload_q    <= '0;
			pps_seen_q  <= 1'b0;
			lock_q      <= 1'b0;
			seconds_q   <= '0;
			stack_cnt_q <= '0;
			last_evt_q  <= '0;
			events_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				ray_ref_q   <= ray_ref_d;
				pps_ref_q   <= pps_ref_d;
				reload_q    <= reload_d;
				pps_seen_q  <= pps_seen_d;
				lock_q      <= lock_d;
				seconds_q   <= seconds_d;
				stack_cnt_q <= stack_cnt_d;
				last_evt_q  <= last_evt_d;
				events_q    <= events_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (fire) res_q <= res_d;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = res_q;

	// Stack count saturates at the limit
	assert property (@(posedge clk) disable iff (!arst_n) stack_cnt_q <= MAX_CNT)
		else $error("stack count beyond limit");

	// A synthetic pulse always drops lock
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.holdover_pulse |-> !res_q.gps_lock)
		else $error("holdover pulse with lock set");

	// A real PPS sets lock and arms the expiry check
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && pop_item.op == OP_PPS |=> lock_q && pps_seen_q)
		else $error("PPS did not set lock");

	// A full stack reports the limit as its slot and leaves the count alone
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && pop_item.op == OP_DETECT && full |=> $stable(stack_cnt_q)
		&& res_q.event_slot == SLOT_W'(MAX_CNT))
		else $error("full stack changed");

endmodule

`default_nettype wire

FILE: rtl/core/pps_disciplined_event_timestamper.sv
// An accepted event is registered in the front end, waits in the queue, and its result
// is registered in the execute stage. Throughput: one event per cycle while the output is
// not stalled; the execute stage updates all timing state from two modular differences per event.
// A two-entry queue separates the input register from the execute stage.
// Reset (arst_n low, asynchronous): all references, counters and flags clear.
// Top level: instantiates pdet_front, pdet_fifo and pdet_back; uses pdet_pkg.
`default_nettype none

module pps_disciplined_event_timestamper #(
	parameter int MAX_EVENTS   = 128,
	parameter int COUNTER_BITS = 32
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_axis_tvalid,
	output logic                       s_axis_tready,
	// [31:0] capture_value
	input  wire [pdet_pkg::CAP_W-1:0]  s_axis_tdata,
	// [1:0] opcode
	input  wire [pdet_pkg::OP_W-1:0]   s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire                        m_axis_tready,
	// [31:0] ray_period, [63:32] ray_after_pps, [95:64] event_time,
	// [103:96] event_slot, [135:104] pps_period, [136] gps_lock,
	// [168:137] seconds_seen, [169] holdover_pulse, [170] stack_full,
	// [202:171] events_total, [207:203] zero
	output logic [pdet_pkg::OUT_W-1:0] m_axis_tdata
);
	import pdet_pkg::*;

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	pdet_front #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_item    (push_item)
	);

	pdet_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	pdet_back #(
		.MAX_EVENTS  (MAX_EVENTS),
		.COUNTER_BITS(COUNTER_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_item     (pop_item),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule

`default_nettype wire

FILE: tb/sv/pps_disciplined_event_timestamper_tb.sv
// Self-checking bench for pps_disciplined_event_timestamper: streams capture requests,
// predicts every timestamp result and compares it field by field on the output stream.
// Depends on pdet_pkg and the timestamper RTL.
`timescale 1ns / 100ps

module pps_disciplined_event_timestamper_tb;
	import pdet_pkg::*;

	localparam int STACK_LIMIT = 128;
	localparam int RANDOM_TARGET = 1050;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_LIMIT = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [CAP_W-1:0] s_axis_tdata = '0;
	logic [OP_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	// Capture requests still to send and timestamp results still owed by the block
	item_t event_queue[$];
	result_t pending_stamps[$];
	item_t drive_item;
	result_t got_stamp;
	result_t want_stamp;

	// Predicted timing state
	logic [CAP_W-1:0] ray_ref;
	logic [CAP_W-1:0] pps_ref;
	logic pps_seen;
	logic lock_q;
	logic [CAP_W-1:0] sec_count;
	int unsigned slot_count;
	logic [CAP_W-1:0] evt_acc;
	logic [CAP_W-1:0] det_count;
	logic [CAP_W-1:0] reload;

	int mismatch_count = 0;
	int checked_count = 0;
	int sent_count = 0;
	int total_items = 0;
	int idle_left = 0;
	int calm_src = 0;
	int stall_left = 0;
	int calm_sink = 0;
	int cycle_count = 0;
	int op_seen[4] = '{0, 0, 0, 0};
	int pulse_count = 0;
	int full_count = 0;
	logic [CAP_W-1:0] clock_now = '0;

	pps_disciplined_event_timestamper #(
		.MAX_EVENTS(STACK_LIMIT),
		.COUNTER_BITS(CAP_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #10 clk = ~clk;

	// Clear predicted state to its reset values
	task automatic clear_timing_state();
		ray_ref = '0;
		pps_ref = '0;
		pps_seen = 1'b0;
		lock_q = 1'b0;
		sec_count = '0;
		slot_count = 0;
		evt_acc = '0;
		det_count = '0;
		reload = '0;
	endtask

	// Advance the predicted state by one request and return its timestamp result
	function automatic result_t timestamp_event(input op_t op, input logic [CAP_W-1:0] cap);
		result_t r;
		logic [CAP_W-1:0] period;
		r = '0;
		case (op)
			OP_DETECT: begin
				period = cap - ray_ref;
				r.ray_period = period;
				r.ray_after_pps = cap - pps_ref;
				ray_ref = cap;
				if (slot_count < STACK_LIMIT) begin
					evt_acc = (slot_count > 0) ? evt_acc + period : period;
					r.event_slot = 8'(slot_count);
					slot_count++;
				end else begin
					// stack full: hold the event time and the slot
					r.stack_full = 1'b1;
					r.event_slot = 8'(slot_count);
				end
				r.event_time = evt_acc;
				det_count = det_count + 1'b1;
			end
			OP_PPS: begin
				r.pps_period = cap - pps_ref;
				reload = cap - pps_ref;
				pps_ref = cap;
				ray_ref = cap;
				sec_count = sec_count + 1'b1;
				lock_q = 1'b1;
				pps_seen = 1'b1;
			end
			OP_EXPIRY: begin
				// no PPS since the last expiry: emit a synthetic second
				if (!pps_seen) begin
					r.holdover_pulse = 1'b1;
					lock_q = 1'b0;
					sec_count = sec_count + 1'b1;
				end
				pps_seen = 1'b0;
				r.pps_period = reload;
			end
			default: ;
		endcase
		r.gps_lock = lock_q;
		r.seconds_seen = sec_count;
		r.events_total = det_count;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [CAP_W-1:0] got_v,
			input logic [CAP_W-1:0] want_v);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got_v, want_v);
	endtask

	task automatic check_result(input result_t got, input result_t want);
		if (got.ray_period !== want.ray_period)
			flag_mismatch("ray_period", got.ray_period, want.ray_period);
		if (got.ray_after_pps !== want.ray_after_pps)
			flag_mismatch("ray_after_pps", got.ray_after_pps, want.ray_after_pps);
		if (got.event_time !== want.event_time)
			flag_mismatch("event_time", got.event_time, want.event_time);
		if (got.event_slot !== want.event_slot)
			flag_mismatch("event_slot", got.event_slot, want.event_slot);
		if (got.pps_period !== want.pps_period)
			flag_mismatch("pps_period", got.pps_period, want.pps_period);
		if (got.gps_lock !== want.gps_lock)
			flag_mismatch("gps_lock", got.gps_lock, want.gps_lock);
		if (got.seconds_seen !== want.seconds_seen)
			flag_mismatch("seconds_seen", got.seconds_seen, want.seconds_seen);
		if (got.holdover_pulse !== want.holdover_pulse)
			flag_mismatch("holdover_pulse", got.holdover_pulse, want.holdover_pulse);
		if (got.stack_full !== want.stack_full)
			flag_mismatch("stack_full", got.stack_full, want.stack_full);
		if (got.events_total !== want.events_total)
			flag_mismatch("events_total", got.events_total, want.events_total);
		if (got.pad !== want.pad)
			flag_mismatch("padding", got.pad, want.pad);
	endtask

	function automatic void push_item(input op_t op, input logic [CAP_W-1:0] cap);
		item_t it;
		it.op = op;
		it.cap = cap;
		event_queue.push_back(it);
	endfunction

	// Next counter value: mostly a forward step, sometimes a big jump or a random value
	function automatic logic [CAP_W-1:0] next_capture();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			clock_now = clock_now + $urandom_range(1, 5000);
		else if (pick < 85)
			clock_now = clock_now + $urandom;
		else
			return $urandom;
		return clock_now;
	endfunction

	// Mostly short gaps, a few long ones, and calm stretches with none
	function automatic int pick_idle(inout int calm);
		int pick;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 3)
			calm = $urandom_range(30, 80);
		if (pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// Build directed and random capture requests
	task automatic build_stimulus();
		int k;
		int pick;
		// first capture after reset, top value and counter wrap
		push_item(OP_DETECT, 32'h0000_1234);
		push_item(OP_DETECT, 32'hFFFF_FFFF);
		push_item(OP_DETECT, 32'h0000_0005);
		push_item(OP_NONE, 32'hFFFF_FFFF);
		// expiry with no PPS ever, then repeated
		push_item(OP_EXPIRY, 32'h0000_0000);
		push_item(OP_EXPIRY, 32'hFFFF_FFFF);
		push_item(OP_PPS, 32'hFFFF_FFF0);
		push_item(OP_DETECT, 32'h0000_0010);
		push_item(OP_DETECT, 32'h0000_0000);
		push_item(OP_EXPIRY, 32'hAAAA_AAAA);
		push_item(OP_EXPIRY, 32'h5555_5555);
		push_item(OP_EXPIRY, 32'h0000_0000);
		push_item(OP_PPS, 32'h0000_0000);
		push_item(OP_PPS, 32'h0000_0000);
		push_item(OP_DETECT, 32'h8000_0000);
		push_item(OP_NONE, 32'h0000_0000);
		push_item(OP_PPS, 32'h7FFF_FFFF);
		push_item(OP_DETECT, 32'h7FFF_FFFF);
		push_item(OP_DETECT, 32'h5555_5555);
		push_item(OP_EXPIRY, 32'h0000_0000);
		push_item(OP_NONE, 32'hAAAA_AAAA);
		clock_now = 32'h0000_0100;
		total_items = event_queue.size();
		while (event_queue.size() < total_items + RANDOM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				// one second: PPS (sometimes lost), detector hits, timer expiry
				if ($urandom_range(0, 4) != 0)
					push_item(OP_PPS, next_capture());
				k = $urandom_range(0, 12);
				repeat (k) push_item(OP_DETECT, next_capture());
				push_item(OP_EXPIRY, $urandom);
			end else begin
				// noise: any kind in any order, unused kind included
				k = $urandom_range(1, 6);
				repeat (k) begin
					case ($urandom_range(0, 3))
						0: push_item(OP_DETECT, next_capture());
						1: push_item(OP_PPS, next_capture());
						2: push_item(OP_EXPIRY, $urandom);
						default: push_item(OP_NONE, $urandom);
					endcase
				end
			end
		end
		total_items = event_queue.size();
	endtask

	// Source side: present requests with random gaps and predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= OP_NONE;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				want_stamp = timestamp_event(op_t'(s_axis_tuser), s_axis_tdata);
				pending_stamps.push_back(want_stamp);
				op_seen[s_axis_tuser]++;
				if (want_stamp.holdover_pulse)
					pulse_count++;
				if (want_stamp.stack_full)
					full_count++;
				sent_count++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (idle_left > 0) begin
					idle_left--;
					s_axis_tvalid <= 1'b0;
				end else if (event_queue.size() > 0) begin
					drive_item = event_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= drive_item.cap;
					s_axis_tuser <= drive_item.op;
					idle_left = pick_idle(calm_src);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Sink side: stall at random and check each accepted result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_stamp = result_t'(m_axis_tdata);
				if (pending_stamps.size() == 0) begin
					flag_mismatch("unexpected result", got_stamp.ray_period, '0);
				end else begin
					check_result(got_stamp, pending_stamps.pop_front());
					checked_count++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				stall_left = pick_idle(calm_sink);
				m_axis_tready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout: %0d of %0d requests sent, %0d results outstanding",
				sent_count, total_items, pending_stamps.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		clear_timing_state();
		build_stimulus();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// wait for every request to go in and every result to come out
		while (sent_count < total_items || pending_stamps.size() > 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
		$display("covered %0d requests (detect %0d, pps %0d, expiry %0d, unused %0d)",
			sent_count, op_seen[OP_DETECT], op_seen[OP_PPS], op_seen[OP_EXPIRY],
			op_seen[OP_NONE]);
		$display("checked %0d results, %0d holdover pulses, %0d stack-full events, %0d mismatches",
			checked_count, pulse_count, full_count, mismatch_count);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/pdet_pkg.sv
rtl/core/pdet_front.sv
rtl/core/pdet_fifo.sv
rtl/core/pdet_back.sv
rtl/core/pps_disciplined_event_timestamper.sv
tb/sv/pps_disciplined_event_timestamper_tb.sv
